// ===== hw/rtl/dcpu_pkg.sv =====
// package for the dcpu16 instruction core: types, opcodes and constants
`default_nettype none
package dcpu_pkg;
    localparam int MEM_WORDS = 65536;
    localparam int MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_EXEC   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [3:0] BOP_NB  = 4'h0;
    localparam logic [3:0] BOP_SET = 4'h1;
    localparam logic [3:0] BOP_ADD = 4'h2;
    localparam logic [3:0] BOP_SUB = 4'h3;
    localparam logic [3:0] BOP_MUL = 4'h4;
    localparam logic [3:0] BOP_DIV = 4'h5;
    localparam logic [3:0] BOP_MOD = 4'h6;
    localparam logic [3:0] BOP_SHL = 4'h7;
    localparam logic [3:0] BOP_SHR = 4'h8;
    localparam logic [3:0] BOP_AND = 4'h9;
    localparam logic [3:0] BOP_BOR = 4'ha;
    localparam logic [3:0] BOP_XOR = 4'hb;
    localparam logic [3:0] BOP_IFE = 4'hc;
    localparam logic [3:0] BOP_IFN = 4'hd;
    localparam logic [3:0] BOP_IFG = 4'he;

    localparam logic [5:0] NB_JSR = 6'h01;
    localparam logic [5:0] NB_SYS = 6'h02;

    typedef enum logic [2:0] {
        LOC_REG, LOC_MEM, LOC_SP, LOC_PC, LOC_O, LOC_LIT
    } loc_kind_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RDWAIT, ST_FETCH, ST_FWAIT, ST_DEC_A, ST_NW_A,
        ST_DEC_B, ST_NW_B, ST_RD_A, ST_RDW_A, ST_RD_B, ST_RDW_B, ST_EXEC,
        ST_DIV, ST_WB, ST_PUSH, ST_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [15:0] remainder;
    } div_rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/dcpu16_instruction_core.sv =====
// top level of the dcpu16 instruction core
// After reset the core sweeps its word memory to zero, one word per cycle, over
// all MEM_WORDS words (65536 by default) before s_tready rises. A write goes
// straight to the result; a read waits for the registered ram output. An
// instruction walks a sequencer around the single port memory: fetch, a read
// per next word, a read for each operand, execute, write back; DIV and MOD
// wait in the bit-serial divider. One word is handled at a time; the result
// sits in an output register so the next word may be taken while it waits.
`default_nettype none
module dcpu16_instruction_core
    import dcpu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // operation[1:0], address[17:2], write_data[33:18]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata   // read_data, program_counter, overflow_word, halted,
                                       // syscall_valid, syscall_id
);
    state_t state_reg, state_next;

    logic [15:0] regs_reg [8];
    logic [15:0] sp_reg, sp_next, pc_reg, pc_next, o_reg, o_next;
    logic        skip_reg, skip_next, halt_reg, halt_next;
    logic [15:0] ins_reg, ins_next;
    loc_kind_t   ka_reg, ka_next, kb_reg, kb_next;
    logic [15:0] va_reg, va_next, vb_reg, vb_next;
    logic [15:0] a_reg, a_next, b_reg, b_next;
    logic [15:0] res_reg, res_next;
    logic        wr_reg, wr_next;
    logic [15:0] rd_reg, rd_next;
    logic        sv_reg, sv_next;
    logic [15:0] sid_reg, sid_next;
    logic [MEM_AW:0] clr_reg, clr_next;
    logic        ov_reg, ov_next;
    logic [71:0] od_reg, od_next;
    logic        reg_we;
    logic [2:0]  reg_wa;
    logic [15:0] reg_wd;

    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [15:0]       mem_wdata, mem_rdata;
    logic [15:0]       maddr;

    div_req_t dreq;
    div_rsp_t drsp;

    logic [3:0]  bop;
    logic [5:0]  ca, cb, cur;
    logic        live, accept, out_free;
    logic [31:0] prod, shl_v, shr_v;
    logic [16:0] sum;

    dcpu_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
        .aclk (aclk), .we (mem_we), .addr (mem_addr), .wdata (mem_wdata), .rdata (mem_rdata)
    );

    dcpu_div u_div (.aclk (aclk), .aresetn (aresetn), .req (dreq), .rsp (drsp));

    assign bop  = ins_reg[3:0];
    assign ca   = ins_reg[9:4];
    assign cb   = ins_reg[15:10];
    assign live = !skip_reg;
    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign mem_addr = maddr[MEM_AW-1:0];
    assign cur      = (state_reg == ST_DEC_A) ? ca : cb;
    assign sum      = {1'b0, a_reg} + {1'b0, b_reg};
    assign prod     = {16'h0, a_reg} * {16'h0, b_reg};
    assign shl_v    = {16'h0, a_reg} << b_reg[4:0];
    assign shr_v    = {a_reg, 16'h0} >> b_reg[4:0];

    function automatic logic [15:0] loc_val(loc_kind_t k, logic [15:0] v, logic [15:0] m,
                                            logic [15:0] r, logic [15:0] s, logic [15:0] p,
                                            logic [15:0] o);
        case (k)
            LOC_REG: loc_val = r;
            LOC_MEM: loc_val = m;
            LOC_SP:  loc_val = s;
            LOC_PC:  loc_val = p;
            LOC_O:   loc_val = o;
            default: loc_val = v;
        endcase
    endfunction

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_reg == (MEM_AW + 1)'(MEM_WORDS - 1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    if (s_tdata[1:0] == OP_READ) state_next = ST_RDWAIT;
                    else if (s_tdata[1:0] == OP_EXEC && !halt_reg) state_next = ST_FETCH;
                    else state_next = ST_DONE;
                end
            end
            ST_RDWAIT: state_next = ST_DONE;
            ST_FETCH:  state_next = ST_FWAIT;
            ST_FWAIT:  state_next = (ins_next[3:0] == BOP_NB) ? ST_DEC_B : ST_DEC_A;
            ST_DEC_A: begin
                if ((ca >= 6'h10 && ca < 6'h18) || ca == 6'h1e || ca == 6'h1f)
                    state_next = ST_NW_A;
                else state_next = ST_DEC_B;
            end
            ST_NW_A:   state_next = ST_DEC_B;
            ST_DEC_B: begin
                if ((cb >= 6'h10 && cb < 6'h18) || cb == 6'h1e || cb == 6'h1f)
                    state_next = ST_NW_B;
                else state_next = live ? ST_RD_A : ST_DONE;
            end
            ST_NW_B:   state_next = live ? ST_RD_A : ST_DONE;
            ST_RD_A:   state_next = ST_RDW_A;
            ST_RDW_A:  state_next = ST_RD_B;
            ST_RD_B:   state_next = ST_RDW_B;
            ST_RDW_B:  state_next = ST_EXEC;
            ST_EXEC: begin
                if (bop == BOP_DIV || bop == BOP_MOD) state_next = (b_reg == 16'h0) ? ST_WB : ST_DIV;
                else if (bop == BOP_NB && ca == NB_JSR) state_next = ST_PUSH;
                else state_next = ST_WB;
            end
            ST_DIV:    if (drsp.done) state_next = ST_WB;
            ST_WB:     state_next = ST_DONE;
            ST_PUSH:   state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        sp_next = sp_reg; pc_next = pc_reg; o_next = o_reg;
        skip_next = skip_reg; halt_next = halt_reg;
        ins_next = ins_reg;
        ka_next = ka_reg; kb_next = kb_reg; va_next = va_reg; vb_next = vb_reg;
        a_next = a_reg; b_next = b_reg; res_next = res_reg; wr_next = wr_reg;
        rd_next = rd_reg; sv_next = sv_reg; sid_next = sid_reg;
        clr_next = clr_reg; ov_next = ov_reg; od_next = od_reg;
        mem_we = 1'b0; maddr = pc_reg; mem_wdata = 16'h0;
        reg_we = 1'b0; reg_wa = 3'd0; reg_wd = 16'h0;
        dreq.start = 1'b0;
        dreq.dividend = (bop == BOP_MOD) ? {16'h0, a_reg} : {a_reg, 16'h0};
        dreq.divisor = b_reg;
        if (ov_reg && m_tready) ov_next = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                maddr = clr_reg[15:0];
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE: begin
                if (accept) begin
                    rd_next = 16'h0; sv_next = 1'b0; sid_next = 16'h0;
                    maddr = s_tdata[17:2];
                    if (s_tdata[1:0] == OP_WRITE) begin
                        mem_we = 1'b1;
                        mem_wdata = s_tdata[33:18];
                    end
                end
            end
            ST_RDWAIT: rd_next = mem_rdata;
            ST_FETCH: begin
                maddr = pc_reg;
                pc_next = pc_reg + 16'd1;
            end
            ST_FWAIT: begin
                ins_next = mem_rdata;
                ka_next = LOC_LIT;
                va_next = {10'h0, mem_rdata[9:4]};
            end
            ST_DEC_A, ST_DEC_B: begin
                if (cur < 6'h08) begin
                    ka_next = LOC_REG; va_next = {13'h0, cur[2:0]};
                end else if (cur < 6'h10) begin
                    ka_next = LOC_MEM; va_next = regs_reg[cur[2:0]];
                end else if (cur < 6'h18) begin
                    ka_next = LOC_MEM; va_next = regs_reg[cur[2:0]];
                    maddr = pc_reg; pc_next = pc_reg + 16'd1;
                end else if (cur == 6'h18) begin
                    ka_next = LOC_MEM; va_next = sp_reg;
                    if (live) sp_next = sp_reg + 16'd1;
                end else if (cur == 6'h19) begin
                    ka_next = LOC_MEM; va_next = sp_reg;
                end else if (cur == 6'h1a) begin
                    ka_next = LOC_MEM;
                    va_next = live ? sp_reg - 16'd1 : sp_reg;
                    if (live) sp_next = sp_reg - 16'd1;
                end else if (cur == 6'h1b) begin
                    ka_next = LOC_SP;
                end else if (cur == 6'h1c) begin
                    ka_next = LOC_PC;
                end else if (cur == 6'h1d) begin
                    ka_next = LOC_O;
                end else if (cur == 6'h1e) begin
                    ka_next = LOC_MEM; va_next = 16'h0;
                    maddr = pc_reg; pc_next = pc_reg + 16'd1;
                end else if (cur == 6'h1f) begin
                    ka_next = LOC_LIT; va_next = 16'h0;
                    maddr = pc_reg; pc_next = pc_reg + 16'd1;
                end else begin
                    ka_next = LOC_LIT; va_next = {10'h0, cur - 6'h20};
                end
                if (state_reg == ST_DEC_B) begin
                    kb_next = ka_next; vb_next = va_next;
                    ka_next = ka_reg; va_next = va_reg;
                    if (!live && !((cb >= 6'h10 && cb < 6'h18) || cb == 6'h1e || cb == 6'h1f))
                        skip_next = 1'b0;
                end
            end
            ST_NW_A: va_next = va_reg + mem_rdata;
            ST_NW_B: begin
                vb_next = vb_reg + mem_rdata;
                if (!live) skip_next = 1'b0;
            end
            ST_RD_A: maddr = va_reg;
            ST_RDW_A: begin
                a_next = loc_val(ka_reg, va_reg, mem_rdata, regs_reg[va_reg[2:0]],
                                 sp_reg, pc_reg, o_reg);
                maddr = vb_reg;
            end
            ST_RD_B: maddr = vb_reg;
            ST_RDW_B: b_next = loc_val(kb_reg, vb_reg, mem_rdata, regs_reg[vb_reg[2:0]],
                                       sp_reg, pc_reg, o_reg);
            ST_EXEC: begin
                wr_next = 1'b1;
                res_next = a_reg;
                case (bop)
                    BOP_NB: begin
                        wr_next = 1'b0;
                        if (ca == NB_JSR) begin
                            sp_next = sp_reg - 16'd1;
                        end else if (ca == NB_SYS) begin
                            if (b_reg == 16'h0) halt_next = 1'b1;
                            else begin sv_next = 1'b1; sid_next = b_reg; end
                        end
                    end
                    BOP_SET: res_next = b_reg;
                    BOP_ADD: begin res_next = sum[15:0]; o_next = {15'h0, sum[16]}; end
                    BOP_SUB: begin
                        res_next = a_reg - b_reg;
                        o_next = (b_reg > a_reg) ? 16'hffff : 16'h0;
                    end
                    BOP_MUL: begin res_next = prod[15:0]; o_next = prod[31:16]; end
                    BOP_DIV, BOP_MOD: begin
                        res_next = 16'h0;
                        if (b_reg == 16'h0) begin
                            if (bop == BOP_DIV) o_next = 16'h0;
                        end else dreq.start = 1'b1;
                    end
                    BOP_SHL: begin
                        if (b_reg >= 16'd32) begin res_next = 16'h0; o_next = 16'h0; end
                        else if (b_reg[4]) begin res_next = 16'h0; o_next = shl_v[31:16]; end
                        else begin res_next = shl_v[15:0]; o_next = shl_v[31:16]; end
                    end
                    BOP_SHR: begin
                        if (b_reg >= 16'd32) begin res_next = 16'h0; o_next = 16'h0; end
                        else begin res_next = shr_v[31:16]; o_next = shr_v[15:0]; end
                    end
                    BOP_AND: res_next = a_reg & b_reg;
                    BOP_BOR: res_next = a_reg | b_reg;
                    BOP_XOR: res_next = a_reg ^ b_reg;
                    BOP_IFE: begin wr_next = 1'b0; skip_next = !(a_reg == b_reg); end
                    BOP_IFN: begin wr_next = 1'b0; skip_next = !(a_reg != b_reg); end
                    BOP_IFG: begin wr_next = 1'b0; skip_next = !(a_reg > b_reg); end
                    default: begin wr_next = 1'b0; skip_next = (a_reg & b_reg) == 16'h0; end
                endcase
            end
            ST_DIV: begin
                if (drsp.done) begin
                    if (bop == BOP_DIV) begin
                        res_next = drsp.quotient[31:16];
                        o_next = drsp.quotient[15:0];
                    end else res_next = drsp.remainder;
                end
            end
            ST_WB: begin
                if (wr_reg) begin
                    case (ka_reg)
                        LOC_REG: begin reg_we = 1'b1; reg_wa = va_reg[2:0]; reg_wd = res_reg; end
                        LOC_MEM: begin mem_we = 1'b1; maddr = va_reg; mem_wdata = res_reg; end
                        LOC_SP:  sp_next = res_reg;
                        LOC_PC:  pc_next = res_reg;
                        LOC_O:   o_next = res_reg;
                        default: ;
                    endcase
                end
            end
            ST_PUSH: begin
                mem_we = 1'b1; maddr = sp_reg; mem_wdata = pc_reg;
                pc_next = b_reg;
            end
            ST_DONE: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    od_next = {6'h0, sid_reg, sv_reg, halt_reg, o_reg, pc_reg, rd_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            sp_reg <= '0; pc_reg <= '0; o_reg <= '0;
            skip_reg <= 1'b0; halt_reg <= 1'b0; ov_reg <= 1'b0; wr_reg <= 1'b0;
            for (int i = 0; i < 8; i++) regs_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            sp_reg <= sp_next; pc_reg <= pc_next; o_reg <= o_next;
            skip_reg <= skip_next; halt_reg <= halt_next; ov_reg <= ov_next;
            wr_reg <= wr_next;
            if (reg_we) regs_reg[reg_wa] <= reg_wd;
        end
        ins_reg <= ins_next;
        ka_reg <= ka_next; kb_reg <= kb_next; va_reg <= va_next; vb_reg <= vb_next;
        a_reg <= a_next; b_reg <= b_next; res_reg <= res_next;
        rd_reg <= rd_next; sv_reg <= sv_next; sid_reg <= sid_next; od_reg <= od_next;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/dcpu_ram.sv =====
// generic single port ram with registered read
`default_nettype none
module dcpu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/dcpu_div.sv =====
// iterative 32 by 16 restoring divider, one quotient bit per cycle
`default_nettype none
module dcpu_div
    import dcpu_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], quo_reg[31]};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[15:0];
endmodule
`default_nettype wire

// ===== hw/rtl/dcpu_checker.sv =====
// port level checks for the dcpu16 instruction core
`default_nettype none
module dcpu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [39:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped while stalled");
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[48] |=> !m_tvalid || m_tdata[48])
        else $error("halt flag cleared");
    a_sys_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[49] |-> m_tdata[65:50] == 16'h0)
        else $error("syscall id without request");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while busy");
    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[49] |-> m_tdata[15:0] == 16'h0)
        else $error("read data on execute");
endmodule

bind dcpu16_instruction_core dcpu_checker u_checker (
    .aclk (aclk), .aresetn (aresetn), .s_tvalid (s_tvalid), .s_tready (s_tready),
    .s_tdata (s_tdata), .m_tvalid (m_tvalid), .m_tready (m_tready), .m_tdata (m_tdata)
);
`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the dcpu16 instruction core
`timescale 1ns / 1ps
`default_nettype none

class core_scoreboard;
    logic [15:0] mem [0:65535];
    logic [15:0] regs [0:7];
    logic [15:0] sp_q, pc_q, o_q;
    bit skip_q, halt_q;
    logic [71:0] pending [$];
    int errors, checked, sys_seen;

    function new();
        foreach (mem[i]) mem[i] = '0;
        foreach (regs[i]) regs[i] = '0;
        sp_q = '0; pc_q = '0; o_q = '0;
        skip_q = 0; halt_q = 0;
        errors = 0; checked = 0; sys_seen = 0;
    endfunction

    function logic [15:0] fetch();
        logic [15:0] w;
        w = mem[pc_q];
        pc_q = pc_q + 16'd1;
        return w;
    endfunction

    function void decode(input logic [5:0] code, input bit live,
                         output dcpu_pkg::loc_kind_t k, output logic [15:0] v);
        k = dcpu_pkg::LOC_LIT;
        v = '0;
        if (code < 6'h08) begin
            k = dcpu_pkg::LOC_REG; v = {13'd0, code[2:0]};
        end else if (code < 6'h10) begin
            k = dcpu_pkg::LOC_MEM; v = regs[code[2:0]];
        end else if (code < 6'h18) begin
            v = fetch() + regs[code[2:0]];
            k = dcpu_pkg::LOC_MEM;
        end else if (code == 6'h18) begin
            k = dcpu_pkg::LOC_MEM; v = sp_q;
            if (live) sp_q = sp_q + 16'd1;
        end else if (code == 6'h19) begin
            k = dcpu_pkg::LOC_MEM; v = sp_q;
        end else if (code == 6'h1a) begin
            if (live) sp_q = sp_q - 16'd1;
            k = dcpu_pkg::LOC_MEM; v = sp_q;
        end else if (code == 6'h1b) begin
            k = dcpu_pkg::LOC_SP;
        end else if (code == 6'h1c) begin
            k = dcpu_pkg::LOC_PC;
        end else if (code == 6'h1d) begin
            k = dcpu_pkg::LOC_O;
        end else if (code == 6'h1e) begin
            k = dcpu_pkg::LOC_MEM; v = fetch();
        end else if (code == 6'h1f) begin
            k = dcpu_pkg::LOC_LIT; v = fetch();
        end else begin
            k = dcpu_pkg::LOC_LIT; v = {10'd0, code - 6'h20};
        end
    endfunction

    function logic [15:0] loc_value(dcpu_pkg::loc_kind_t k, logic [15:0] v);
        case (k)
            dcpu_pkg::LOC_REG: return regs[v[2:0]];
            dcpu_pkg::LOC_MEM: return mem[v];
            dcpu_pkg::LOC_SP:  return sp_q;
            dcpu_pkg::LOC_PC:  return pc_q;
            dcpu_pkg::LOC_O:   return o_q;
            default:           return v;
        endcase
    endfunction

    function void loc_store(dcpu_pkg::loc_kind_t k, logic [15:0] v, logic [15:0] w);
        case (k)
            dcpu_pkg::LOC_REG: regs[v[2:0]] = w;
            dcpu_pkg::LOC_MEM: mem[v] = w;
            dcpu_pkg::LOC_SP:  sp_q = w;
            dcpu_pkg::LOC_PC:  pc_q = w;
            dcpu_pkg::LOC_O:   o_q = w;
            default: ;
        endcase
    endfunction

    function void run_instruction(output bit sv, output logic [15:0] sid);
        logic [15:0] ins, va, vb;
        logic [3:0] op;
        logic [5:0] ca, cb;
        dcpu_pkg::loc_kind_t ka, kb;
        logic [31:0] a, b, r;
        bit live;
        sv = 0; sid = '0;
        ins = fetch();
        op = ins[3:0]; ca = ins[9:4]; cb = ins[15:10];
        live = !skip_q;
        if (op != dcpu_pkg::BOP_NB) decode(ca, live, ka, va);
        else begin
            ka = dcpu_pkg::LOC_LIT; va = {10'd0, ca};
        end
        decode(cb, live, kb, vb);
        if (!live) begin
            skip_q = 0;
            return;
        end
        a = {16'd0, loc_value(ka, va)};
        b = {16'd0, loc_value(kb, vb)};
        case (op)
            dcpu_pkg::BOP_NB: begin
                if (ca == dcpu_pkg::NB_JSR) begin
                    sp_q = sp_q - 16'd1;
                    mem[sp_q] = pc_q;
                    pc_q = b[15:0];
                end else if (ca == dcpu_pkg::NB_SYS) begin
                    if (b == 0) halt_q = 1;
                    else begin
                        sv = 1; sid = b[15:0];
                    end
                end
            end
            dcpu_pkg::BOP_SET: loc_store(ka, va, b[15:0]);
            dcpu_pkg::BOP_ADD: begin
                r = a + b;
                o_q = (r > 32'hffff) ? 16'd1 : 16'd0;
                loc_store(ka, va, r[15:0]);
            end
            dcpu_pkg::BOP_SUB: begin
                o_q = (b > a) ? 16'hffff : 16'd0;
                r = a - b;
                loc_store(ka, va, r[15:0]);
            end
            dcpu_pkg::BOP_MUL: begin
                r = a * b;
                o_q = r[31:16];
                loc_store(ka, va, r[15:0]);
            end
            dcpu_pkg::BOP_DIV: begin
                if (b == 0) begin
                    o_q = '0; loc_store(ka, va, 16'd0);
                end else begin
                    r = (a << 16) / b;
                    o_q = r[15:0];
                    r = a / b;
                    loc_store(ka, va, r[15:0]);
                end
            end
            dcpu_pkg::BOP_MOD: begin
                r = (b == 0) ? 32'd0 : a % b;
                loc_store(ka, va, r[15:0]);
            end
            dcpu_pkg::BOP_SHL: begin
                if (b >= 32) begin
                    o_q = '0; loc_store(ka, va, 16'd0);
                end else begin
                    r = a << b;
                    o_q = r[31:16];
                    loc_store(ka, va, r[15:0]);
                end
            end
            dcpu_pkg::BOP_SHR: begin
                if (b >= 32) begin
                    o_q = '0; loc_store(ka, va, 16'd0);
                end else begin
                    r = (a << 16) >> b;
                    o_q = r[15:0];
                    r = a >> b;
                    loc_store(ka, va, r[15:0]);
                end
            end
            dcpu_pkg::BOP_AND: loc_store(ka, va, a[15:0] & b[15:0]);
            dcpu_pkg::BOP_BOR: loc_store(ka, va, a[15:0] | b[15:0]);
            dcpu_pkg::BOP_XOR: loc_store(ka, va, a[15:0] ^ b[15:0]);
            dcpu_pkg::BOP_IFE: skip_q = !(a == b);
            dcpu_pkg::BOP_IFN: skip_q = !(a != b);
            dcpu_pkg::BOP_IFG: skip_q = !(a > b);
            default:           skip_q = !((a & b) != 0);
        endcase
    endfunction

    function void note(logic [1:0] op, logic [15:0] addr, logic [15:0] data);
        logic [15:0] rd, sid;
        bit sv;
        rd = '0; sv = 0; sid = '0;
        if (op == dcpu_pkg::OP_WRITE) mem[addr] = data;
        else if (op == dcpu_pkg::OP_READ) rd = mem[addr];
        else if (op == dcpu_pkg::OP_EXEC && !halt_q) run_instruction(sv, sid);
        if (sv) sys_seen++;
        pending.push_back({6'd0, sid, sv, halt_q, o_q, pc_q, rd});
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("mismatch on word %0d: %s expected %h actual %h",
                         checked, name, want, got);
        end
    endfunction

    function void check(logic [71:0] got);
        logic [71:0] want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %h", got);
            return;
        end
        want = pending.pop_front();
        compare("read_data", want[15:0], got[15:0]);
        compare("program_counter", want[31:16], got[31:16]);
        compare("overflow_word", want[47:32], got[47:32]);
        compare("halted", {15'd0, want[48]}, {15'd0, got[48]});
        compare("syscall_valid", {15'd0, want[49]}, {15'd0, got[49]});
        compare("syscall_id", want[65:50], got[65:50]);
        checked++;
    endfunction
endclass

module testbench;
    import dcpu_pkg::*;

    localparam int LIMIT = 3000000;

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid, m_tready;
    logic [71:0] m_tdata;

    core_scoreboard sb;
    int idle_pct, stall_pct, sent, cycles;

    dcpu16_instruction_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        sb = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        idle_pct = 0;
        stall_pct = 0;
        sent = 0;
        cycles = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check(m_tdata);
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send(logic [1:0] op, logic [15:0] addr, logic [15:0] data);
        bit lowered;
        lowered = 0;
        while ($urandom_range(0, 99) < idle_pct) begin
            if (!lowered) s_tvalid <= 0;
            lowered = 1;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'd0, data, addr, op};
        do @(posedge aclk); while (!s_tready);
        sb.note(op, addr, data);
        sent++;
    endtask

    function automatic logic [15:0] encode(logic [3:0] op, logic [5:0] ca, logic [5:0] cb);
        return {cb, ca, op};
    endfunction

    // place an instruction and its next words at the predicted pc, then step it
    task automatic run_at_pc(logic [15:0] ins, logic [15:0] w1, logic [15:0] w2);
        logic [15:0] p;
        p = sb.pc_q;
        send(OP_WRITE, p, ins);
        send(OP_WRITE, p + 16'd1, w1);
        send(OP_WRITE, p + 16'd2, w2);
        send(OP_EXEC, 16'($urandom), 16'($urandom));
    endtask

    task automatic random_instruction();
        logic [3:0] op;
        logic [5:0] ca, cb;
        logic [15:0] w1, w2;
        op = 4'($urandom_range(0, 15));
        ca = 6'($urandom_range(0, 63));
        cb = 6'($urandom_range(0, 63));
        w1 = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
        w2 = 16'($urandom);
        if (op == BOP_NB) begin
            if ($urandom_range(0, 9) < 9) ca = $urandom_range(0, 1) ? NB_JSR : NB_SYS;
            // keep the core running: only nonzero literal system call ids
            if (ca == NB_SYS) begin
                cb = $urandom_range(0, 1) ? 6'h1f : 6'($urandom_range(6'h21, 6'h3f));
                if (w1 == 0) w1 = 16'd1;
            end
        end
        run_at_pc(encode(op, ca, cb), w1, w2);
    endtask

    initial begin
        int r;
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        send(OP_WRITE, 16'h0000, 16'hffff);
        send(OP_WRITE, 16'hffff, 16'h0000);
        send(OP_READ, 16'h0000, 16'h0000);
        send(OP_READ, 16'hffff, 16'hffff);
        send(OP_UNUSED, 16'h1234, 16'h5678);
        run_at_pc(encode(BOP_SET, 6'h00, 6'h1f), 16'hffff, 16'h0);
        run_at_pc(encode(BOP_ADD, 6'h00, 6'h21), 16'h0, 16'h0);
        run_at_pc(encode(BOP_SUB, 6'h01, 6'h21), 16'h0, 16'h0);
        run_at_pc(encode(BOP_MUL, 6'h01, 6'h01), 16'h0, 16'h0);
        run_at_pc(encode(BOP_DIV, 6'h01, 6'h20), 16'h0, 16'h0);
        run_at_pc(encode(BOP_MOD, 6'h01, 6'h20), 16'h0, 16'h0);
        run_at_pc(encode(BOP_SHL, 6'h01, 6'h1f), 16'd32, 16'h0);
        run_at_pc(encode(BOP_SHR, 6'h01, 6'h24), 16'h0, 16'h0);
        run_at_pc(encode(BOP_IFN, 6'h01, 6'h01), 16'h0, 16'h0);
        // skipped instruction with a next word and a stack push
        run_at_pc(encode(BOP_SET, 6'h1a, 6'h1f), 16'h7777, 16'h0);
        run_at_pc(encode(BOP_NB, NB_JSR, 6'h1f), 16'h8000, 16'h0);
        run_at_pc(encode(BOP_NB, NB_SYS, 6'h25), 16'h0, 16'h0);
        run_at_pc(encode(BOP_NB, 6'h3f, 6'h21), 16'h0, 16'h0);

        while (sent < 1550) begin
            case ((sent * 5) / 1550)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 72; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 72; end
                3: begin idle_pct = 20; stall_pct = 20; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            r = $urandom_range(0, 99);
            if (r < 70) random_instruction();
            else if (r < 80) send(OP_EXEC, 16'($urandom), 16'($urandom));
            else if (r < 90) send(OP_WRITE, 16'($urandom), 16'($urandom));
            else if (r < 97) send(OP_READ, $urandom_range(0, 1) ? sb.sp_q : 16'($urandom),
                                  16'($urandom));
            else send(OP_UNUSED, 16'($urandom), 16'($urandom));
        end

        // halt, then show that reads and writes still act
        idle_pct = 0;
        stall_pct = 0;
        run_at_pc(encode(BOP_NB, NB_SYS, 6'h20), 16'h0, 16'h0);
        send(OP_EXEC, 16'h0, 16'h0);
        send(OP_WRITE, 16'h00ab, 16'hbeef);
        send(OP_READ, 16'h00ab, 16'h0);
        @(posedge aclk);
        s_tvalid <= 0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("%0d words sent, %0d results checked, %0d system call requests",
                 sent, sb.checked, sb.sys_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
